// ===== rtl/assert_macros.svh =====
// assertion macros shared by the des rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/des_pkg.sv =====
// des package: permutation tables, s-boxes, key schedule and round function
// no dependencies
`default_nettype none

package des_pkg;

	localparam int unsigned BlockW  = 64;
	localparam int unsigned KeyW    = 64;
	localparam int unsigned NRounds = 16;

	typedef logic [63:0] block_t;
	typedef logic [27:0] half_key_t;
	typedef logic [47:0] subkey_t;

	typedef logic [6:0] tab_t [64];

	localparam tab_t TabIp = '{
		7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2, 7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
		7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6, 7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
		7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,  7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
		7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5, 7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};

	localparam tab_t TabFp = '{
		7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32, 7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
		7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30, 7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
		7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28, 7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
		7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26, 7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};

	localparam logic [5:0] TabE [48] = '{
		6'd32,6'd1,6'd2,6'd3,6'd4,6'd5, 6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,
		6'd8,6'd9,6'd10,6'd11,6'd12,6'd13, 6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,
		6'd16,6'd17,6'd18,6'd19,6'd20,6'd21, 6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,
		6'd24,6'd25,6'd26,6'd27,6'd28,6'd29, 6'd28,6'd29,6'd30,6'd31,6'd32,6'd1};

	localparam logic [5:0] TabP [32] = '{
		6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17, 6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
		6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9, 6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25};

	localparam logic [6:0] TabPc1 [56] = '{
		7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9, 7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
		7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27, 7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
		7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15, 7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
		7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29, 7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};

	localparam logic [5:0] TabPc2 [48] = '{
		6'd14,6'd17,6'd11,6'd24,6'd1,6'd5, 6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,
		6'd23,6'd19,6'd12,6'd4,6'd26,6'd8, 6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,
		6'd41,6'd52,6'd31,6'd37,6'd47,6'd55, 6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,
		6'd44,6'd49,6'd39,6'd56,6'd34,6'd53, 6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};

	localparam logic [1:0] RotSched [16] = '{
		2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};

	localparam logic [3:0] Sbox [8][64] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		  4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		  4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		  4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		  4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		  4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		  4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		  4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		  4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		  4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		  4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		  4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		  4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		  4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		  4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		  4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		  4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		  4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		  4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		  4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		  4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		  4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		  4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		  4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		  4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

	function automatic block_t perm64(input block_t din, input tab_t tab);
		block_t r;
		for (int k = 0; k < 64; k++) r[63-k] = din[64-int'(tab[k])];
		return r;
	endfunction

	function automatic logic [55:0] pc1(input logic [63:0] key);
		logic [55:0] r;
		for (int k = 0; k < 56; k++) r[55-k] = key[64-int'(TabPc1[k])];
		return r;
	endfunction

	function automatic subkey_t pc2(input half_key_t c, input half_key_t d);
		logic [55:0] cd;
		subkey_t r;
		cd = {c, d};
		for (int k = 0; k < 48; k++) r[47-k] = cd[56-int'(TabPc2[k])];
		return r;
	endfunction

	function automatic half_key_t rot28(input half_key_t v, input logic [1:0] s);
		return (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t sk);
		logic [47:0] x;
		logic [31:0] c;
		logic [31:0] p;
		logic [5:0]  six;
		for (int k = 0; k < 48; k++) x[47-k] = r[32-int'(TabE[k])];
		x = x ^ sk;
		for (int i = 0; i < 8; i++) begin
			six = x[47-6*i -: 6];
			c[31-4*i -: 4] = Sbox[i][{six[5], six[0], six[4:1]}];
		end
		for (int k = 0; k < 32; k++) p[31-k] = c[32-int'(TabP[k])];
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/des_round.sv =====
// des_round: one registered feistel round with its own key schedule step
// depends on des_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module des_round #(
	parameter logic [1:0] Shift = 2'd1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               valid_in,
	input  wire logic [31:0]        l_in,
	input  wire logic [31:0]        r_in,
	input  wire des_pkg::half_key_t c_in,
	input  wire des_pkg::half_key_t d_in,
	output logic                    valid_out,
	output logic [31:0]             l_out,
	output logic [31:0]             r_out,
	output des_pkg::half_key_t      c_out,
	output des_pkg::half_key_t      d_out
);
	import des_pkg::*;

	half_key_t c_n, d_n;

	assign c_n = rot28(c_in, Shift);
	assign d_n = rot28(d_in, Shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (en) valid_out <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_out <= r_in;
			r_out <= l_in ^ feistel(r_in, pc2(c_n, d_n));
			c_out <= c_n;
			d_out <= d_n;
		end
	end

	`ASSERT_NEXT(a_hold, clk, arst_n, !en, $stable(valid_out) && $stable(r_out))
endmodule

`default_nettype wire

// ===== rtl/des_block_encrypt.sv =====
// des_block_encrypt: single des encryption, 18-stage pipeline
// depends on des_pkg, des_round and assert_macros.svh
//
// channel  | handshake              | payload
// input    | valid / stall          | plain_block
// output   | out_valid / out_stall  | cipher_block
// config   | key_we                 | key_wdata
//
// one transaction per cycle unless stalled; stages in order: ip stage, 16 rounds, fp stage
// every stage holds when the output register is full and stalled
// key schedule travels with each transaction from the ip stage
// reset clears valid bits and the key register
`default_nettype none
`include "assert_macros.svh"

module des_block_encrypt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        key_we,
	input  wire logic [63:0] key_wdata,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic [63:0] plain_block,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      cipher_block
);
	import des_pkg::*;

	logic [63:0] cipher_key_q;
	logic        en;
	logic        v_s [17];
	logic [31:0] l_s [17];
	logic [31:0] r_s [17];
	half_key_t   c_s [17];
	half_key_t   d_s [17];
	block_t      ip_w;
	logic [55:0] k56_w;

	// whole pipe advances unless the output register is held
	assign en    = !(out_valid && out_stall);
	assign stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cipher_key_q <= '0;
		else if (key_we) cipher_key_q <= key_wdata;
	end

	assign ip_w  = perm64(plain_block, TabIp);
	assign k56_w = pc1(cipher_key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s[0] <= ip_w[63:32];
			r_s[0] <= ip_w[31:0];
			c_s[0] <= k56_w[55:28];
			d_s[0] <= k56_w[27:0];
		end
	end

	for (genvar g = 0; g < 16; g++) begin : g_round
		des_round #(.Shift(RotSched[g])) u_round (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_in(v_s[g]), .l_in(l_s[g]), .r_in(r_s[g]), .c_in(c_s[g]), .d_in(d_s[g]),
			.valid_out(v_s[g+1]), .l_out(l_s[g+1]), .r_out(r_s[g+1]),
			.c_out(c_s[g+1]), .d_out(d_s[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s[16];
	end

	always_ff @(posedge clk) begin
		if (en) cipher_block <= perm64({r_s[16], l_s[16]}, TabFp);
	end

	`ASSERT_IMP(a_stall_full, clk, arst_n, stall, out_valid && out_stall)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(cipher_block))
	`ASSERT_NEXT(a_last_round, clk, arst_n, en && v_s[16], out_valid)
endmodule

`default_nettype wire
